/* rtl/core/gdb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdb_pkg: shared types and constants of the distance and bearing unit
// Fixed-point constants, the CORDIC arctangent table and the request and
// response bundles of the shared CORDIC unit.
// ----------------------------------------------------------------------------
package gdb_pkg;

	// datapath width of the CORDIC x and y registers
	localparam int CW = 36;
	// width of the CORDIC angle accumulator
	localparam int ZW = 34;

	localparam logic signed [CW-1:0] KINV_Q30 = 36'sd652032874;
	localparam logic [33:0] PI_Q28 = 34'd843314857;
	localparam logic [30:0] Q30_ONE = 31'h40000000;
	localparam logic [24:0] DIST_MAX = 25'h1FFFFFF;

	typedef struct packed {
		logic start;
		logic vec;
		logic [31:0] ang;
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
	} cdc_req_t;

	typedef struct packed {
		logic done;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0] z;
	} cdc_rsp_t;

	// arctan(2^-i) in units of 2^32 per turn
	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0: v = 34'sd536870912;
			5'd1: v = 34'sd316933406;
			5'd2: v = 34'sd167458907;
			5'd3: v = 34'sd85004756;
			5'd4: v = 34'sd42667331;
			5'd5: v = 34'sd21354465;
			5'd6: v = 34'sd10679838;
			5'd7: v = 34'sd5340245;
			5'd8: v = 34'sd2670163;
			5'd9: v = 34'sd1335087;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41722;
			5'd15: v = 34'sd20861;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2608;
			5'd19: v = 34'sd1304;
			5'd20: v = 34'sd652;
			5'd21: v = 34'sd326;
			5'd22: v = 34'sd163;
			5'd23: v = 34'sd81;
			5'd24: v = 34'sd41;
			5'd25: v = 34'sd20;
			5'd26: v = 34'sd10;
			5'd27: v = 34'sd5;
			5'd28: v = 34'sd3;
			5'd29: v = 34'sd1;
			5'd30: v = 34'sd1;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/gdb_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdb_cordic: iterative CORDIC unit
// Rotation mode gives sine and cosine of an angle, vectoring mode gives the
// angle of a vector; one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module gdb_cordic
	import gdb_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cdc_req_t req,
	output cdc_rsp_t      rsp
);

	localparam int IW = $clog2(STEPS);

	logic signed [CW-1:0] x_q, y_q, dx, dy, xn, yn;
	logic signed [ZW-1:0] z_q, zn, at;
	logic [IW-1:0] i_q;
	logic busy_q, done_q, vec_q, neg_q, pos;
	logic [31:0] angf;
	logic fold;

	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = atan_entry(5'(i_q));
		if (vec_q) begin
			pos = y_q[CW-1] || (y_q == '0);
		end else begin
			pos = !z_q[ZW-1];
		end
		if (pos) begin
			xn = x_q - dx;
			yn = y_q + dy;
			zn = z_q - at;
		end else begin
			xn = x_q + dx;
			yn = y_q - dy;
			zn = z_q + at;
		end
		// fold the second and third quadrant onto the first and fourth
		fold = (req.ang[31:30] == 2'b01) || (req.ang[31:30] == 2'b10);
		angf = {req.ang[31] ^ fold, req.ang[30:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				i_q <= '0;
				if (req.vec && req.vx == '0 && req.vy == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (i_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			vec_q <= req.vec;
			if (req.vec) begin
				neg_q <= 1'b0;
				if (req.vx == '0 && req.vy == '0) begin
					x_q <= '0;
					y_q <= '0;
					z_q <= '0;
				end else if (req.vx[CW-1]) begin
					x_q <= -req.vx;
					y_q <= -req.vy;
					z_q <= 34'sh080000000;
				end else begin
					x_q <= req.vx;
					y_q <= req.vy;
					z_q <= '0;
				end
			end else begin
				neg_q <= fold;
				x_q   <= KINV_Q30;
				y_q   <= '0;
				z_q   <= {{2{angf[31]}}, angf};
			end
		end else if (busy_q) begin
			z_q <= zn;
			if (i_q == IW'(STEPS - 1) && neg_q) begin
				x_q <= -xn;
				y_q <= -yn;
			end else begin
				x_q <= xn;
				y_q <= yn;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;
	assign rsp.z    = z_q[31:0];

endmodule
`default_nettype wire

/* rtl/core/gdb_isqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdb_isqrt: bit-serial integer square root
// Floor square root of a 62-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module gdb_isqrt
	import gdb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [61:0] val,
	output logic             done,
	output logic [30:0]      root
);

	logic [61:0] rad_q;
	logic [31:0] rem_q;
	logic [30:0] root_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q, ge;
	logic [33:0] remn, trial, diff;

	always_comb begin
		remn  = {rem_q, rad_q[61:60]};
		trial = {1'b0, root_q, 2'b01};
		diff  = remn - trial;
		ge    = remn >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[59:0], 2'b00};
			if (ge) begin
				rem_q  <= diff[31:0];
				root_q <= {root_q[29:0], 1'b1};
			end else begin
				rem_q  <= remn[31:0];
				root_q <= {root_q[29:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

/* rtl/core/gps_distance_bearing_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gps_distance_bearing_unit: great-circle distance and bearing
// Tracks position and heading from fix items; answers query items with the
// haversine distance and the relative bearing to a target.
// ----------------------------------------------------------------------------
// A fix item (tuser 0) whose latitude plus longitude is zero only raises the
// no-fix flag; any other fix stores the position and sets the heading to the
// initial great-circle bearing from the previous position (zero if the
// position is unchanged). A query item (tuser 1) returns the distance in
// metres and the target bearing minus the heading. Every item gives exactly
// one result item. Items are handled one at a time under a sequencer that
// drives one shared CORDIC unit (one micro-rotation a cycle), one bit-serial
// square root (one root bit a cycle) and one registered multiplier. The time
// an item takes is set by its CORDIC passes and multiplier steps, for a query
// also by the two square roots; a zero bearing vector shortens its pass. A
// zero-sum fix goes from idle straight to the final state. A result that
// cannot leave holds the sequencer in its last state; the input is ready
// again in the same cycle that the result is presented, even while that
// result still waits in the output register.
// ----------------------------------------------------------------------------
module gps_distance_bearing_unit
	import gdb_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // latitude[31:0], longitude[63:32]
	input  wire logic        s_tuser,   // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // distance_m[24:0], relative_bearing[40:25],
	                                    // heading[56:41], zero[63:57]
	output logic             m_tuser,   // no_fix
	input  wire logic        cfg_we,
	input  wire logic [22:0] cfg_wdata  // earth_radius_m
);

	typedef enum logic [23:0] {
		S_IDLE = 24'h000001,
		S_SC1  = 24'h000002,
		S_SC2  = 24'h000004,
		S_SC3  = 24'h000008,
		S_M1   = 24'h000010,
		S_M2   = 24'h000020,
		S_M3   = 24'h000040,
		S_M4   = 24'h000080,
		S_M5   = 24'h000100,
		S_ATB  = 24'h000200,
		S_SC4  = 24'h000400,
		S_SC5  = 24'h000800,
		S_M6   = 24'h001000,
		S_M7   = 24'h002000,
		S_M8   = 24'h004000,
		S_M9   = 24'h008000,
		S_M10  = 24'h010000,
		S_SQA  = 24'h020000,
		S_SQB  = 24'h040000,
		S_ATH  = 24'h080000,
		S_M11  = 24'h100000,
		S_M12  = 24'h200000,
		S_M13  = 24'h400000,
		S_FIN  = 24'h800000
	} state_t;

	function automatic logic signed [33:0] ext34(input logic [31:0] v);
		return {{2{v[31]}}, v};
	endfunction

	state_t state_q, state_d;
	logic first_q;

	// architectural state
	logic [31:0] cur_lat_q, cur_lon_q;
	logic [15:0] heading_q;
	logic nofix_q;
	logic [22:0] radius_q;

	// item being worked on
	logic cmd_q, eq_q, zsum_q;
	logic [31:0] lat2_q, lon2_q;

	// intermediate values
	logic [31:0] s1_q, c1_q, s2_q, c2_q, sd_q, cd_q, sh_q, sl_q;
	logic [31:0] bx_q, ty_q, t_q, v_q;
	logic [32:0] by_q;
	logic [30:0] a_q, sa_q, sb_q, half_q;
	logic [15:0] tb_q;
	logic [24:0] dist_q;

	// shared multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_q;

	cdc_req_t cdc_req;
	cdc_rsp_t cdc_rsp;
	logic sq_start, sq_done;
	logic [61:0] sq_val;
	logic [30:0] sq_root;

	logic [32:0] dlat, dlon, zsum, a_raw;
	logic [30:0] a_cl, one_minus_a;
	logic [67:0] dsum;
	logic [29:0] dval;
	logic [15:0] tb_eff;
	logic out_free, accept;

	logic m_valid_q, m_user_q;
	logic [63:0] m_data_q;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		dlat  = {lat2_q[31], lat2_q} - {cur_lat_q[31], cur_lat_q};
		dlon  = {lon2_q[31], lon2_q} - {cur_lon_q[31], cur_lon_q};
		zsum  = {s_tdata[31], s_tdata[31:0]} + {s_tdata[63], s_tdata[63:32]};
		// haversine term, clamp to [0, 1]
		a_raw = prod_q[62:30] + {v_q[31], v_q};
		if (a_raw[32]) begin
			a_cl = '0;
		end else if (a_raw > {2'b00, Q30_ONE}) begin
			a_cl = Q30_ONE;
		end else begin
			a_cl = a_raw[30:0];
		end
		one_minus_a = Q30_ONE - a_q;
		dsum   = prod_q + (68'd1 << 37);
		dval   = dsum[67:38];
		tb_eff = eq_q ? 16'd0 : tb_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!s_tuser && zsum == '0) begin
						state_d = S_FIN;
					end else begin
						state_d = S_SC1;
					end
				end
			end
			S_SC1: if (cdc_rsp.done) state_d = S_SC2;
			S_SC2: if (cdc_rsp.done) state_d = S_SC3;
			S_SC3: if (cdc_rsp.done) state_d = S_M1;
			S_M1:  state_d = S_M2;
			S_M2:  state_d = S_M3;
			S_M3:  state_d = S_M4;
			S_M4:  state_d = S_M5;
			S_M5:  state_d = S_ATB;
			S_ATB: begin
				if (cdc_rsp.done) begin
					state_d = cmd_q ? S_SC4 : S_FIN;
				end
			end
			S_SC4: if (cdc_rsp.done) state_d = S_SC5;
			S_SC5: if (cdc_rsp.done) state_d = S_M6;
			S_M6:  state_d = S_M7;
			S_M7:  state_d = S_M8;
			S_M8:  state_d = S_M9;
			S_M9:  state_d = S_M10;
			S_M10: state_d = S_SQA;
			S_SQA: if (sq_done) state_d = S_SQB;
			S_SQB: if (sq_done) state_d = S_ATH;
			S_ATH: if (cdc_rsp.done) state_d = S_M11;
			S_M11: state_d = S_M12;
			S_M12: state_d = S_M13;
			S_M13: state_d = S_FIN;
			S_FIN: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// operand selection for the shared units
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		cdc_req.start = 1'b0;
		cdc_req.vec   = 1'b0;
		cdc_req.ang   = '0;
		cdc_req.vx    = '0;
		cdc_req.vy    = '0;
		sq_start = 1'b0;
		sq_val   = '0;
		case (state_q)
			S_SC1: begin
				cdc_req.start = first_q;
				cdc_req.ang   = cur_lat_q;
			end
			S_SC2: begin
				cdc_req.start = first_q;
				cdc_req.ang   = lat2_q;
			end
			S_SC3: begin
				cdc_req.start = first_q;
				cdc_req.ang   = lon2_q - cur_lon_q;
			end
			S_M1: begin
				mul_a = ext34(c2_q);
				mul_b = ext34(sd_q);
			end
			S_M2: begin
				mul_a = ext34(c1_q);
				mul_b = ext34(s2_q);
			end
			S_M3: begin
				mul_a = ext34(s1_q);
				mul_b = ext34(c2_q);
			end
			S_M4: begin
				mul_a = prod_q[63:30];
				mul_b = ext34(cd_q);
			end
			S_ATB: begin
				cdc_req.start = first_q;
				cdc_req.vec   = 1'b1;
				cdc_req.vx    = {{3{by_q[32]}}, by_q};
				cdc_req.vy    = {{4{bx_q[31]}}, bx_q};
			end
			S_SC4: begin
				cdc_req.start = first_q;
				cdc_req.ang   = dlat[32:1];
			end
			S_SC5: begin
				cdc_req.start = first_q;
				cdc_req.ang   = dlon[32:1];
			end
			S_M6: begin
				mul_a = ext34(c1_q);
				mul_b = ext34(c2_q);
			end
			S_M7: begin
				mul_a = ext34(sl_q);
				mul_b = ext34(sl_q);
			end
			S_M8: begin
				mul_a = ext34(t_q);
				mul_b = prod_q[63:30];
			end
			S_M9: begin
				mul_a = ext34(sh_q);
				mul_b = ext34(sh_q);
			end
			S_SQA: begin
				sq_start = first_q;
				sq_val   = {1'b0, a_q, 30'd0};
			end
			S_SQB: begin
				sq_start = first_q;
				sq_val   = {1'b0, one_minus_a, 30'd0};
			end
			S_ATH: begin
				cdc_req.start = first_q;
				cdc_req.vec   = 1'b1;
				cdc_req.vx    = {5'd0, sb_q};
				cdc_req.vy    = {5'd0, sa_q};
			end
			S_M11: begin
				mul_a = {11'd0, radius_q};
				mul_b = PI_Q28;
			end
			S_M12: begin
				// R*pi in metres, 8 fraction bits
				mul_a = prod_q[53:20];
				mul_b = {3'd0, half_q};
			end
			default: begin
			end
		endcase
	end

	gdb_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cdc_req),
		.rsp    (cdc_rsp)
	);

	gdb_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.val    (sq_val),
		.done   (sq_done),
		.root   (sq_root)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			first_q   <= 1'b0;
			cur_lat_q <= '0;
			cur_lon_q <= '0;
			heading_q <= '0;
			nofix_q   <= 1'b0;
			radius_q  <= 23'd6371301;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// start a shared unit in the first cycle of its state
			first_q <= (state_d != state_q);
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == S_FIN && out_free) begin
				m_valid_q <= 1'b1;
				if (!cmd_q) begin
					if (zsum_q) begin
						nofix_q <= 1'b1;
					end else begin
						nofix_q   <= 1'b0;
						heading_q <= tb_eff;
						cur_lat_q <= lat2_q;
						cur_lon_q <= lon2_q;
					end
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			cmd_q  <= s_tuser;
			lat2_q <= s_tdata[31:0];
			lon2_q <= s_tdata[63:32];
			eq_q   <= (s_tdata[31:0] == cur_lat_q) && (s_tdata[63:32] == cur_lon_q);
			zsum_q <= !s_tuser && (zsum == '0);
			dist_q <= '0;
		end
		case (state_q)
			S_SC1: if (cdc_rsp.done) begin
				s1_q <= cdc_rsp.y[31:0];
				c1_q <= cdc_rsp.x[31:0];
			end
			S_SC2: if (cdc_rsp.done) begin
				s2_q <= cdc_rsp.y[31:0];
				c2_q <= cdc_rsp.x[31:0];
			end
			S_SC3: if (cdc_rsp.done) begin
				sd_q <= cdc_rsp.y[31:0];
				cd_q <= cdc_rsp.x[31:0];
			end
			S_M2:  bx_q <= prod_q[61:30];
			S_M3:  ty_q <= prod_q[61:30];
			S_M5:  by_q <= {ty_q[31], ty_q} - prod_q[62:30];
			// round the bearing to 16 bits
			S_ATB: if (cdc_rsp.done) tb_q <= cdc_rsp.z[31:16] + {15'd0, cdc_rsp.z[15]};
			S_SC4: if (cdc_rsp.done) sh_q <= cdc_rsp.y[31:0];
			S_SC5: if (cdc_rsp.done) sl_q <= cdc_rsp.y[31:0];
			S_M7:  t_q <= prod_q[61:30];
			S_M9:  v_q <= prod_q[61:30];
			S_M10: a_q <= a_cl;
			S_SQA: if (sq_done) sa_q <= sq_root;
			S_SQB: if (sq_done) sb_q <= sq_root;
			// clamp the half central angle to a quarter turn
			S_ATH: if (cdc_rsp.done) begin
				half_q <= (cdc_rsp.z > {1'b0, Q30_ONE}) ? Q30_ONE : cdc_rsp.z[30:0];
			end
			S_M13: dist_q <= (dval > {5'd0, DIST_MAX}) ? DIST_MAX : dval[24:0];
			S_FIN: if (out_free) begin
				if (cmd_q) begin
					m_data_q <= {7'd0, heading_q, tb_eff - heading_q, dist_q};
					m_user_q <= nofix_q;
				end else if (zsum_q) begin
					m_data_q <= {7'd0, heading_q, 16'd0, 25'd0};
					m_user_q <= 1'b1;
				end else begin
					m_data_q <= {7'd0, tb_eff, 16'd0, 25'd0};
					m_user_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// a CORDIC result arrives only in a state that waits for one
	a_cdc_done: assert property (@(posedge clk) disable iff (!arst_n)
		cdc_rsp.done |-> (state_q == S_SC1 || state_q == S_SC2 || state_q == S_SC3 ||
			state_q == S_ATB || state_q == S_SC4 || state_q == S_SC5 || state_q == S_ATH))
		else $error("CORDIC result outside a CORDIC state");

	// a root arrives only in a square-root state
	a_sq_done: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == S_SQA || state_q == S_SQB))
		else $error("square root result outside a root state");

	// finishing an item always presents a result
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> m_tvalid)
		else $error("finished item gave no result");

endmodule
`default_nettype wire
